// ===== rtl/epphe_pkg.sv =====
// Shared types, constants and header sizing helpers for the encapsulation header encoder.
`timescale 1ns / 1ps

package epphe_pkg;

  // Field widths
  localparam int unsigned VERSION_W  = 3;
  localparam int unsigned PID_W      = 3;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned CCSDS_W    = 16;
  localparam int unsigned LENGTH_W   = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HEADER_W   = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned REM_W      = 3;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [VERSION_W-1:0] VERSION_RESET  = 3'd7;
  localparam logic [PID_W-1:0]     EXT_CODE_RESET = 3'd6;

  // Length thresholds for the header size choice
  localparam logic [LENGTH_W-1:0] LEN_MAX_SHORT = 32'h0000_00FF;
  localparam logic [LENGTH_W-1:0] LEN_MAX_MID   = 32'h0000_FFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_CODE = 2'd1;

  // Header size code, as written into the low bits of the first byte
  typedef enum logic [1:0] {
    SZ_ONE   = 2'd0,
    SZ_TWO   = 2'd1,
    SZ_FOUR  = 2'd2,
    SZ_EIGHT = 2'd3
  } size_code_t;

  // One encoded header waiting for the serialiser
  typedef struct packed {
    logic [HEADER_W-1:0] bytes;
    size_code_t          code;
    logic                ovf;
  } hdr_entry_t;

  // Smallest header that holds the optional fields and the length
  function automatic size_code_t hdr_code(input logic [LENGTH_W-1:0] len,
                                          input logic force_four,
                                          input logic has_ccsds);
    size_code_t sz;
    if (has_ccsds || (len > LEN_MAX_MID)) begin
      sz = SZ_EIGHT;
    end else if (force_four || (len > LEN_MAX_SHORT)) begin
      sz = SZ_FOUR;
    end else if (len != '0) begin
      sz = SZ_TWO;
    end else begin
      sz = SZ_ONE;
    end
    return sz;
  endfunction

  // Index of the last byte for a size code
  function automatic logic [REM_W-1:0] last_index(input size_code_t code);
    logic [REM_W-1:0] idx;
    case (code)
      SZ_ONE:   idx = 3'd0;
      SZ_TWO:   idx = 3'd1;
      SZ_FOUR:  idx = 3'd3;
      SZ_EIGHT: idx = 3'd7;
      default:  idx = 3'd0;
    endcase
    return idx;
  endfunction

endpackage

// ===== rtl/epp_header_encoder_unit.sv =====
// Top level of the encapsulation packet header encoder.
//
// Usage: each word on the input channel (in_valid / in_ready) describes one
// packet header. The block emits that header as 1, 2, 4 or 8 bytes on the
// output channel (out_valid / out_ready), first byte first, with last_byte
// high on the final one and length_overflow repeated on every byte.
// Path: the input word is written into the queue, then loaded into the
// serialiser's shift register, where its first byte is shown.
// Throughput: one byte per cycle while out_ready is high; the single byte
// output port sets that rate. A queue of QUEUE_DEPTH headers sits between
// sizing and serialising, so new words are taken while earlier headers are
// still leaving.
// Configuration: cfg_wen with cfg_index 0 writes the version number, index 1
// the protocol id that forces a four byte header; write only while idle.
// Reset: rst empties the queue, drops any header in flight and restores
// version 7 and extended id code 6.
// Stall: while out_ready is low the current byte holds; once the queue fills,
// in_ready drops until the serialiser frees a slot.
`timescale 1ns / 1ps

module epp_header_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = epphe_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [epphe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [epphe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [epphe_pkg::PID_W-1:0]       pid_value,
  input  logic                              has_id_extension,
  input  logic [epphe_pkg::NIBBLE_W-1:0]    id_extension,
  input  logic                              has_user_nibble,
  input  logic [epphe_pkg::NIBBLE_W-1:0]    user_nibble,
  input  logic                              has_ccsds_word,
  input  logic [epphe_pkg::CCSDS_W-1:0]     ccsds_word,
  input  logic [epphe_pkg::LENGTH_W-1:0]    length_value,
  input  logic                              length_is_payload,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [epphe_pkg::BYTE_W-1:0]      header_byte,
  output logic                              last_byte,
  output logic                              length_overflow
);

  epphe_pkg::hdr_entry_t new_entry, head_entry;
  logic                  q_not_full, q_not_empty, q_pop, q_push;

  assign in_ready = q_not_full;
  assign q_push   = in_valid && q_not_full;

  // Size and lay out the incoming header
  epphe_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pid_value         (pid_value),
    .has_id_extension  (has_id_extension),
    .id_extension      (id_extension),
    .has_user_nibble   (has_user_nibble),
    .user_nibble       (user_nibble),
    .has_ccsds_word    (has_ccsds_word),
    .ccsds_word        (ccsds_word),
    .length_value      (length_value),
    .length_is_payload (length_is_payload),
    .entry             (new_entry)
  );

  // Hold encoded headers until the serialiser is free
  epphe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (new_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (head_entry)
  );

  // Send the header out a byte at a time
  epphe_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_not_empty),
    .q_head          (head_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .header_byte     (header_byte),
    .last_byte       (last_byte),
    .length_overflow (length_overflow)
  );

endmodule

// ===== rtl/epphe_front.sv =====
// Front end: configuration registers, header sizing and byte layout of one description.
`timescale 1ns / 1ps

module epphe_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [epphe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [epphe_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [epphe_pkg::PID_W-1:0]         pid_value,
  input  logic                                has_id_extension,
  input  logic [epphe_pkg::NIBBLE_W-1:0]      id_extension,
  input  logic                                has_user_nibble,
  input  logic [epphe_pkg::NIBBLE_W-1:0]      user_nibble,
  input  logic                                has_ccsds_word,
  input  logic [epphe_pkg::CCSDS_W-1:0]       ccsds_word,
  input  logic [epphe_pkg::LENGTH_W-1:0]      length_value,
  input  logic                                length_is_payload,
  output epphe_pkg::hdr_entry_t               entry
);

  logic [epphe_pkg::VERSION_W-1:0] version_number;
  logic [epphe_pkg::PID_W-1:0]     extended_id_code;

  logic                               force_four;
  logic [epphe_pkg::LENGTH_W:0]       cand_sum [4];
  logic [epphe_pkg::LENGTH_W-1:0]     cand_len [4];
  logic                               cand_ovf [4];
  epphe_pkg::size_code_t              cand_sz  [4];
  epphe_pkg::size_code_t              sz0, sz1, sz2, sz3, sz_fin;
  logic [epphe_pkg::LENGTH_W-1:0]     len_fin;
  logic                               ovf_fin;
  logic [epphe_pkg::BYTE_W-1:0]       byte0, nib_byte;
  logic [epphe_pkg::CCSDS_W-1:0]      opt_word;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      version_number   <= epphe_pkg::VERSION_RESET;
      extended_id_code <= epphe_pkg::EXT_CODE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        epphe_pkg::REG_VERSION:  version_number   <= cfg_data;
        epphe_pkg::REG_EXT_CODE: extended_id_code <= cfg_data;
        default: ;
      endcase
    end
  end

  assign force_four = (pid_value == extended_id_code) || has_id_extension || has_user_nibble;

  // Derived length for every possible header size, evaluated side by side
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cand_sum[i] = {1'b0, length_value} + 33'((1 << i) - 1);
      cand_ovf[i] = cand_sum[i][epphe_pkg::LENGTH_W];
      cand_len[i] = cand_ovf[i] ? '1 : cand_sum[i][epphe_pkg::LENGTH_W-1:0];
      cand_sz[i]  = epphe_pkg::hdr_code(cand_len[i], force_four, has_ccsds_word);
    end
  end

  // Follow the size chain; it settles within three steps since size only grows
  always_comb begin
    sz0 = epphe_pkg::hdr_code(length_value, force_four, has_ccsds_word);
    sz1 = cand_sz[sz0];
    sz2 = cand_sz[sz1];
    sz3 = cand_sz[sz2];
    if (length_is_payload) begin
      sz_fin  = sz3;
      len_fin = cand_len[sz3];
      ovf_fin = cand_ovf[sz3];
    end else begin
      sz_fin  = sz0;
      len_fin = length_value;
      ovf_fin = 1'b0;
    end
  end

  // Lay out the header, first byte in the top bits
  always_comb begin
    byte0    = {version_number, pid_value, sz_fin};
    nib_byte = {has_user_nibble ? user_nibble : 4'h0,
                has_id_extension ? id_extension : 4'h0};
    opt_word = has_ccsds_word ? ccsds_word : '0;
    case (sz_fin)
      epphe_pkg::SZ_ONE:   entry.bytes = {byte0, 56'h0};
      epphe_pkg::SZ_TWO:   entry.bytes = {byte0, len_fin[7:0], 48'h0};
      epphe_pkg::SZ_FOUR:  entry.bytes = {byte0, nib_byte, len_fin[15:0], 32'h0};
      epphe_pkg::SZ_EIGHT: entry.bytes = {byte0, nib_byte, opt_word, len_fin};
      default:             entry.bytes = {byte0, 56'h0};
    endcase
    entry.code = sz_fin;
    entry.ovf  = ovf_fin;
  end

endmodule

// ===== rtl/epphe_queue.sv =====
// Short flip-flop queue of encoded headers between front and back.
`timescale 1ns / 1ps

module epphe_queue #(
  parameter int unsigned DEPTH = epphe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  epphe_pkg::hdr_entry_t push_entry,
  output logic                  not_full,
  input  logic                  pop,
  output logic                  not_empty,
  output epphe_pkg::hdr_entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  epphe_pkg::hdr_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count < CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("fill count did not grow on push");

endmodule

// ===== rtl/epphe_back.sv =====
// Back end: serialises one queued header into bytes on the output channel.
`timescale 1ns / 1ps

module epphe_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  epphe_pkg::hdr_entry_t             q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [epphe_pkg::BYTE_W-1:0]      header_byte,
  output logic                              last_byte,
  output logic                              length_overflow
);

  logic                              busy;
  logic [epphe_pkg::HEADER_W-1:0]    shreg;
  logic [epphe_pkg::REM_W-1:0]       remaining;
  logic                              ovf;

  // Take the next header when idle or when the last byte leaves
  assign q_pop = q_valid && (!busy || (out_ready && (remaining == '0)));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (!busy || out_ready) begin
      if (!busy || (remaining == '0)) begin
        busy <= q_valid;
      end
    end
  end

  // Load or shift the header word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      shreg     <= q_head.bytes;
      remaining <= epphe_pkg::last_index(q_head.code);
      ovf       <= q_head.ovf;
    end else if (busy && out_ready && (remaining != '0)) begin
      shreg     <= {shreg[epphe_pkg::HEADER_W-epphe_pkg::BYTE_W-1:0],
                    {epphe_pkg::BYTE_W{1'b0}}};
      remaining <= remaining - 1'b1;
    end
  end

  assign out_valid       = busy;
  assign header_byte     = shreg[epphe_pkg::HEADER_W-1 -: epphe_pkg::BYTE_W];
  assign last_byte       = (remaining == '0);
  assign length_overflow = ovf;

  a_mid_header_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_byte) |=> out_valid)
    else $error("header ended before its last byte");

  a_pop_at_boundary: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!busy || (out_ready && last_byte)))
    else $error("new header loaded mid header");

endmodule

// ===== verif/epp_header_encoder_unit_tb.sv =====
// Testbench for the encapsulation packet header encoder: random and directed headers, checked byte by byte.
`timescale 1ns / 1ps

module epp_header_encoder_unit_tb;

  // One header description as it crosses the input channel
  typedef struct {
    logic [epphe_pkg::PID_W-1:0]    pid;
    logic                           has_ext;
    logic [epphe_pkg::NIBBLE_W-1:0] ext;
    logic                           has_usr;
    logic [epphe_pkg::NIBBLE_W-1:0] usr;
    logic                           has_ccsds;
    logic [epphe_pkg::CCSDS_W-1:0]  ccsds;
    logic [epphe_pkg::LENGTH_W-1:0] length;
    logic                           is_payload;
  } hdr_desc_t;

  // One header byte as it leaves the output channel
  typedef struct {
    logic [epphe_pkg::BYTE_W-1:0] data;
    logic                         last;
    logic                         ovf;
  } hdr_byte_t;

  // Predicts the header bytes of each accepted word and checks them on the way out
  class header_byte_board;
    logic [epphe_pkg::VERSION_W-1:0] version;
    logic [epphe_pkg::PID_W-1:0]     ext_code;
    hdr_byte_t                       pending_bytes[$];
    int                              errors;

    function new();
      version  = epphe_pkg::VERSION_RESET;
      ext_code = epphe_pkg::EXT_CODE_RESET;
      errors   = 0;
    endfunction

    task report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    // Smallest header that fits the optional fields and the length
    function epphe_pkg::size_code_t pick_size(input logic [epphe_pkg::LENGTH_W-1:0] len,
                                              input hdr_desc_t h);
      if (h.has_ccsds || len > 32'h0000_FFFF) return epphe_pkg::SZ_EIGHT;
      if (h.pid == ext_code || h.has_ext || h.has_usr || len > 32'h0000_00FF)
        return epphe_pkg::SZ_FOUR;
      if (len != '0) return epphe_pkg::SZ_TWO;
      return epphe_pkg::SZ_ONE;
    endfunction

    function void note_header(input hdr_desc_t h);
      epphe_pkg::size_code_t          code;
      epphe_pkg::size_code_t          code_next;
      logic [epphe_pkg::LENGTH_W:0]   sum;
      logic [epphe_pkg::LENGTH_W-1:0] len;
      logic                           ovf;
      logic [epphe_pkg::NIBBLE_W-1:0] ext;
      logic [epphe_pkg::NIBBLE_W-1:0] usr;
      logic [epphe_pkg::CCSDS_W-1:0]  ccsds;
      logic [epphe_pkg::BYTE_W-1:0]   b[8];
      int                             n;
      hdr_byte_t                      e;
      len  = h.length;
      ovf  = 1'b0;
      code = pick_size(len, h);
      // Derive the length field from the payload until the size settles
      if (h.is_payload) begin
        for (int k = 0; k < 4; k++) begin
          sum = {1'b0, h.length} + ((epphe_pkg::LENGTH_W+1)'(1) << code) - 1'b1;
          ovf = sum[epphe_pkg::LENGTH_W];
          len = ovf ? '1 : sum[epphe_pkg::LENGTH_W-1:0];
          code_next = pick_size(len, h);
          if (code_next == code) break;
          code = code_next;
        end
      end
      // Zero the fields that are absent
      ext   = h.has_ext ? h.ext : '0;
      usr   = h.has_usr ? h.usr : '0;
      ccsds = h.has_ccsds ? h.ccsds : '0;
      for (int k = 0; k < 8; k++) b[k] = '0;
      case (code)
        epphe_pkg::SZ_ONE: begin
        end
        epphe_pkg::SZ_TWO: begin
          b[1] = len[7:0];
        end
        epphe_pkg::SZ_FOUR: begin
          b[1] = {usr, ext};
          b[2] = len[15:8];
          b[3] = len[7:0];
        end
        default: begin
          b[1] = {usr, ext};
          b[2] = ccsds[15:8];
          b[3] = ccsds[7:0];
          b[4] = len[31:24];
          b[5] = len[23:16];
          b[6] = len[15:8];
          b[7] = len[7:0];
        end
      endcase
      b[0] = {version, h.pid, 2'(code)};
      n = 1 << code;
      for (int k = 0; k < n; k++) begin
        e.data = b[k];
        e.last = (k == n - 1);
        e.ovf  = ovf;
        pending_bytes.push_back(e);
      end
    endfunction

    task check_byte(input hdr_byte_t got);
      hdr_byte_t e;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", got.data));
      end else begin
        e = pending_bytes.pop_front();
        if (got.data !== e.data)
          report_mismatch($sformatf("header_byte %02h, want %02h", got.data, e.data));
        if (got.last !== e.last)
          report_mismatch($sformatf("last_byte %b, want %b", got.last, e.last));
        if (got.ovf !== e.ovf)
          report_mismatch($sformatf("length_overflow %b, want %b", got.ovf, e.ovf));
      end
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_wen;
  logic [epphe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [epphe_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic [epphe_pkg::PID_W-1:0]      pid_value;
  logic                             has_id_extension;
  logic [epphe_pkg::NIBBLE_W-1:0]   id_extension;
  logic                             has_user_nibble;
  logic [epphe_pkg::NIBBLE_W-1:0]   user_nibble;
  logic                             has_ccsds_word;
  logic [epphe_pkg::CCSDS_W-1:0]    ccsds_word;
  logic [epphe_pkg::LENGTH_W-1:0]   length_value;
  logic                             length_is_payload;
  logic                             out_valid;
  logic                             out_ready;
  logic [epphe_pkg::BYTE_W-1:0]     header_byte;
  logic                             last_byte;
  logic                             length_overflow;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  header_byte_board board;

  epp_header_encoder_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .pid_value         (pid_value),
    .has_id_extension  (has_id_extension),
    .id_extension      (id_extension),
    .has_user_nibble   (has_user_nibble),
    .user_nibble       (user_nibble),
    .has_ccsds_word    (has_ccsds_word),
    .ccsds_word        (ccsds_word),
    .length_value      (length_value),
    .length_is_payload (length_is_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .header_byte       (header_byte),
    .last_byte         (last_byte),
    .length_overflow   (length_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  // Stall the output at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note each accepted header word
  always @(posedge clk) begin
    hdr_desc_t h;
    if (!rst && in_valid && in_ready) begin
      h.pid        = pid_value;
      h.has_ext    = has_id_extension;
      h.ext        = id_extension;
      h.has_usr    = has_user_nibble;
      h.usr        = user_nibble;
      h.has_ccsds  = has_ccsds_word;
      h.ccsds      = ccsds_word;
      h.length     = length_value;
      h.is_payload = length_is_payload;
      board.note_header(h);
    end
  end

  // Check each accepted header byte
  always @(posedge clk) begin
    hdr_byte_t got;
    if (!rst && out_valid && out_ready) begin
      got.data = header_byte;
      got.last = last_byte;
      got.ovf  = length_overflow;
      board.check_byte(got);
    end
  end

  function automatic hdr_desc_t make_hdr(input logic [epphe_pkg::PID_W-1:0] pid,
                                         input logic has_ext,
                                         input logic [epphe_pkg::NIBBLE_W-1:0] ext,
                                         input logic has_usr,
                                         input logic [epphe_pkg::NIBBLE_W-1:0] usr,
                                         input logic has_ccsds,
                                         input logic [epphe_pkg::CCSDS_W-1:0] ccsds,
                                         input logic [epphe_pkg::LENGTH_W-1:0] length,
                                         input logic is_payload);
    hdr_desc_t h;
    h.pid        = pid;
    h.has_ext    = has_ext;
    h.ext        = ext;
    h.has_usr    = has_usr;
    h.usr        = usr;
    h.has_ccsds  = has_ccsds;
    h.ccsds      = ccsds;
    h.length     = length;
    h.is_payload = is_payload;
    return h;
  endfunction

  // Lengths cluster around the size thresholds and the top of the range
  function automatic hdr_desc_t random_hdr();
    hdr_desc_t h;
    h.pid        = epphe_pkg::PID_W'($urandom_range(7));
    h.has_ext    = ($urandom_range(99) < 30);
    h.ext        = epphe_pkg::NIBBLE_W'($urandom());
    h.has_usr    = ($urandom_range(99) < 30);
    h.usr        = epphe_pkg::NIBBLE_W'($urandom());
    h.has_ccsds  = ($urandom_range(99) < 25);
    h.ccsds      = epphe_pkg::CCSDS_W'($urandom());
    h.is_payload = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: h.length = '0;
      1: h.length = $urandom_range(1, 255);
      2: h.length = 32'd252 + $urandom_range(6);
      3: h.length = 32'h0000_FFF8 + $urandom_range(15);
      4: h.length = 32'hFFFF_FFF0 + $urandom_range(15);
      5: h.length = $urandom_range(256, 65535);
      default: h.length = $urandom();
    endcase
    return h;
  endfunction

  // Present one word, idling first at random, and hold it until taken
  task automatic send_header(input hdr_desc_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    pid_value         <= h.pid;
    has_id_extension  <= h.has_ext;
    id_extension      <= h.ext;
    has_user_nibble   <= h.has_usr;
    user_nibble       <= h.usr;
    has_ccsds_word    <= h.has_ccsds;
    ccsds_word        <= h.ccsds;
    length_value      <= h.length;
    length_is_payload <= h.is_payload;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, then wait for every expected byte and let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_registers(input logic [epphe_pkg::VERSION_W-1:0] version,
                                 input logic [epphe_pkg::PID_W-1:0] ext_code);
    cfg_wen   <= 1'b1;
    cfg_index <= epphe_pkg::REG_VERSION;
    cfg_data  <= version;
    @(posedge clk);
    cfg_index <= epphe_pkg::REG_EXT_CODE;
    cfg_data  <= ext_code;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.version  = version;
    board.ext_code = ext_code;
  endtask

  initial begin
    logic [epphe_pkg::VERSION_W-1:0] versions[8];
    logic [epphe_pkg::PID_W-1:0]     ext_codes[8];
    board = new();
    versions  = '{3'd0, 3'd7, 3'd3, 3'd0, 3'd7, 3'd5, 3'd2, 3'd4};
    ext_codes = '{3'd0, 3'd7, 3'd5, 3'd7, 3'd0, 3'd2, 3'd6, 3'd1};
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    rst               <= 1'b1;
    cfg_wen           <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_valid          <= 1'b0;
    pid_value         <= '0;
    has_id_extension  <= 1'b0;
    id_extension      <= '0;
    has_user_nibble   <= 1'b0;
    user_nibble       <= '0;
    has_ccsds_word    <= 1'b0;
    ccsds_word        <= '0;
    length_value      <= '0;
    length_is_payload <= 1'b0;
    out_ready         <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed headers under the reset settings
    send_header(make_hdr(3'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0));
    send_header(make_hdr(3'd1, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_0001, 1'b0));
    send_header(make_hdr(3'd2, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_00FF, 1'b0));
    send_header(make_hdr(3'd3, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_0100, 1'b0));
    send_header(make_hdr(3'd4, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_FFFF, 1'b0));
    send_header(make_hdr(3'd5, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0001_0000, 1'b0));
    send_header(make_hdr(3'd7, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'hFFFF_FFFF, 1'b0));
    // Protocol id equal to the extended code forces four bytes
    send_header(make_hdr(3'd6, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_0000, 1'b0));
    // Absent nibbles and CCSDS field are written as zero
    send_header(make_hdr(3'd0, 1'b1, 4'hF, 1'b0, 4'hF, 1'b0, 16'hFFFF, 32'h0000_0000, 1'b0));
    send_header(make_hdr(3'd0, 1'b0, 4'h5, 1'b1, 4'hA, 1'b0, 16'h0000, 32'h0000_0003, 1'b0));
    send_header(make_hdr(3'd1, 1'b0, 4'h0, 1'b0, 4'h0, 1'b1, 16'hFFFF, 32'h0000_0000, 1'b0));
    send_header(make_hdr(3'd2, 1'b0, 4'h0, 1'b0, 4'h0, 1'b1, 16'hABCD, 32'h0000_0042, 1'b0));
    send_header(make_hdr(3'd7, 1'b1, 4'hF, 1'b1, 4'hF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    // Payload mode: size settles after one or more passes
    send_header(make_hdr(3'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_0000, 1'b1));
    send_header(make_hdr(3'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_0001, 1'b1));
    send_header(make_hdr(3'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_00FE, 1'b1));
    send_header(make_hdr(3'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_00FF, 1'b1));
    send_header(make_hdr(3'd1, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'h0000_FFFD, 1'b1));
    send_header(make_hdr(3'd2, 1'b0, 4'h0, 1'b0, 4'h0, 1'b1, 16'h1234, 32'h0000_0005, 1'b1));
    // Derived length at the 32-bit limit and just past it
    send_header(make_hdr(3'd3, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'hFFFF_FFF8, 1'b1));
    send_header(make_hdr(3'd3, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'hFFFF_FFF9, 1'b1));
    send_header(make_hdr(3'd4, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 16'h0000, 32'hFFFF_FFFF, 1'b1));
    drain();

    // Random headers over several settings and idling patterns
    for (int phase = 0; phase < 8; phase++) begin
      write_registers(versions[phase], ext_codes[phase]);
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 17;
          recv_stall_pct = 17;
        end
      endcase
      for (int k = 0; k < 42; k++) send_header(random_hdr());
      drain();
    end

    repeat (10) @(posedge clk);
    if (board.pending_bytes.size() != 0)
      board.report_mismatch($sformatf("%0d bytes never arrived", board.pending_bytes.size()));
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/epphe_pkg.sv
rtl/epphe_front.sv
rtl/epphe_queue.sv
rtl/epphe_back.sv
rtl/epp_header_encoder_unit.sv
verif/epp_header_encoder_unit_tb.sv
